@@ design/modular_exponentiator_assert.svh @@
`ifndef MODULAR_EXPONENTIATOR_ASSERT_SVH
`define MODULAR_EXPONENTIATOR_ASSERT_SVH

// checked only out of reset
`define MODEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked also across reset
`define MODEXP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/modexp_pkg.sv @@
package modexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [1:0] {
    OP_RED,
    OP_MUL,
    OP_SQR
  } op_t;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic wb;
    logic shift_exp;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_bit;
    logic exp_last;
    logic cnt_done;
  } sts_t;

endpackage

@@ design/modular_exponentiator.sv @@
// Modular exponentiator: out_power_result = in_base_value ** in_exponent_value mod
// in_modulus_value, by right-to-left square and multiply. A beat is taken when start is
// high and busy is low; the result shows for exactly one cycle with out_valid and
// cannot be held off, so the receiver must take it then. A zero modulus returns 0
// with out_zero_modulus_error set, going from the check state straight to output. Otherwise the base is first
// reduced, then each exponent bit below the highest set one costs a squaring (none for
// the highest), plus a multiply when the bit is set; every such modular operation runs
// on one bit-serial double-and-add unit at one multiplier bit per cycle, each set up,
// stepped through all WIDTH multiplier bits and written back, and each bit gets an
// evaluate state that looks at the exponent.
// An exponent of zero gives 1 even for a modulus of 1.
module modular_exponentiator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [modexp_pkg::WIDTH-1:0]  in_base_value,
  input  logic [modexp_pkg::WIDTH-1:0]  in_exponent_value,
  input  logic [modexp_pkg::WIDTH-1:0]  in_modulus_value,
  output logic                          out_valid,
  output logic [modexp_pkg::WIDTH-1:0]  out_power_result,
  output logic                          out_zero_modulus_error
);

  modexp_pkg::cmd_t cmd;
  modexp_pkg::sts_t sts;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  modexp_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_base_value          (in_base_value),
    .in_exponent_value      (in_exponent_value),
    .in_modulus_value       (in_modulus_value),
    .out_power_result       (out_power_result),
    .out_zero_modulus_error (out_zero_modulus_error)
  );

endmodule

@@ design/modexp_ctrl.sv @@
`include "modular_exponentiator_assert.svh"

module modexp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output modexp_pkg::cmd_t  cmd,
  input  modexp_pkg::sts_t  sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INIT,
    S_RUN,
    S_WB,
    S_EVAL,
    S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  modexp_pkg::op_t kind_r, kind_nxt;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cmd           = '0;
    cmd.op        = kind_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mod_zero) begin
          state_nxt = S_OUT;
        end else begin
          kind_nxt  = modexp_pkg::OP_RED;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.cnt_done) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.wb = 1'b1;
        case (kind_r)
          modexp_pkg::OP_MUL: begin
            if (sts.exp_last) begin
              state_nxt = S_OUT;
            end else begin
              kind_nxt  = modexp_pkg::OP_SQR;
              state_nxt = S_INIT;
            end
          end
          modexp_pkg::OP_SQR: begin
            cmd.shift_exp = 1'b1;
            state_nxt     = S_EVAL;
          end
          default: begin
            state_nxt = S_EVAL;
          end
        endcase
      end
      S_EVAL: begin
        if (sts.exp_zero) begin
          state_nxt = S_OUT;
        end else if (sts.exp_bit) begin
          kind_nxt  = modexp_pkg::OP_MUL;
          state_nxt = S_INIT;
        end else begin
          kind_nxt  = modexp_pkg::OP_SQR;
          state_nxt = S_INIT;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= modexp_pkg::OP_RED;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  `MODEXP_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `MODEXP_ASSERT(a_accept_busy, (start && !busy) |=> (busy && !out_valid), "accepted beat not taken up")
  `MODEXP_ASSERT(a_step_only_run, cmd.step |-> !cmd.wb && !cmd.init, "datapath commands overlap")
  `MODEXP_ASSERT_RST(a_reset_idle, !rst_n |=> !busy, "busy after reset")

endmodule

@@ design/modexp_dp.sv @@
module modexp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  modexp_pkg::cmd_t              cmd,
  output modexp_pkg::sts_t              sts,
  input  logic [modexp_pkg::WIDTH-1:0]  in_base_value,
  input  logic [modexp_pkg::WIDTH-1:0]  in_exponent_value,
  input  logic [modexp_pkg::WIDTH-1:0]  in_modulus_value,
  output logic [modexp_pkg::WIDTH-1:0]  out_power_result,
  output logic                          out_zero_modulus_error
);

  localparam int W = modexp_pkg::WIDTH;

  logic [W-1:0]                  sq_r, exp_r, mod_r, acc_r, prod_r, mplr_r, addend_r;
  logic [modexp_pkg::CNT_W-1:0]  cnt_r;
  logic [W:0]                    dbl_sum, add_sum;
  logic [W-1:0]                  dbl_mod, add_mod, prod_nxt, one_mod;

  // one double-and-add step, operands below the modulus
  always_comb begin
    dbl_sum  = {prod_r, 1'b0};
    dbl_mod  = (dbl_sum >= {1'b0, mod_r}) ? W'(dbl_sum - {1'b0, mod_r}) : W'(dbl_sum);
    add_sum  = {1'b0, dbl_mod} + {1'b0, addend_r};
    add_mod  = (add_sum >= {1'b0, mod_r}) ? W'(add_sum - {1'b0, mod_r}) : W'(add_sum);
    prod_nxt = mplr_r[W-1] ? add_mod : dbl_mod;
  end

  assign one_mod = (mod_r == W'(1)) ? '0 : W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.init) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_r  <= in_base_value;
      exp_r <= in_exponent_value;
      mod_r <= in_modulus_value;
      acc_r <= W'(1);
    end
    if (cmd.init) begin
      prod_r <= '0;
      case (cmd.op)
        modexp_pkg::OP_RED: begin
          mplr_r   <= sq_r;
          addend_r <= one_mod;
        end
        modexp_pkg::OP_MUL: begin
          mplr_r   <= acc_r;
          addend_r <= sq_r;
        end
        default: begin
          mplr_r   <= sq_r;
          addend_r <= sq_r;
        end
      endcase
    end
    if (cmd.step) begin
      prod_r <= prod_nxt;
      mplr_r <= {mplr_r[W-2:0], 1'b0};
    end
    if (cmd.wb) begin
      if (cmd.op == modexp_pkg::OP_MUL) begin
        acc_r <= prod_r;
      end else begin
        sq_r <= prod_r;
      end
    end
    if (cmd.shift_exp) begin
      exp_r <= {1'b0, exp_r[W-1:1]};
    end
  end

  always_comb begin
    sts.mod_zero = (mod_r == '0);
    sts.exp_zero = (exp_r == '0);
    sts.exp_bit  = exp_r[0];
    sts.exp_last = (exp_r[W-1:1] == '0);
    sts.cnt_done = (cnt_r == modexp_pkg::CNT_W'(W - 1));
  end

  assign out_power_result       = sts.mod_zero ? '0 : acc_r;
  assign out_zero_modulus_error = sts.mod_zero;

endmodule
